// ===== hdl/cfla_pkg.sv =====
package cfla_pkg;

  localparam int unsigned StoreSlotsDef = 4096;
  localparam int unsigned MaxChunksDef  = 16;
  localparam int unsigned ChunkCapDef   = 1024;
  localparam int unsigned FirstSlotsRst = 16;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned SlotW   = 12;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OpenW   = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_GC    = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_GC_KEPT  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [SlotW-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot_out;
    logic [OpenW-1:0]   chunks_open;
  } rsp_t;

endpackage

// ===== hdl/chunked_free_list_allocator_core.sv =====
// Chunked slot allocator with a doubly linked free list held in synchronous
// memories with registered reads. Items are taken one at a time: start is
// accepted while busy is low, and exactly one result is shown for one cycle on
// done_o, unless a cfg write aborts the item. Busy stays high while the item is
// in work; a free of an out-of-range slot, an unknown command, a failed growth
// and a gc of the first chunk go straight to the result.
// An alloc on an empty list opens a new chunk, linking one slot per cycle; gc
// scans the newest chunk for used slots, then unlinks each slot by reading its
// links, waiting for the read and rewriting its neighbours. After reset or a
// write of first_chunk_slots the first chunk is linked one slot per cycle with
// busy high; the whole busy-flag memory is swept clear in the same pass. The
// receiver cannot stall results.
module chunked_free_list_allocator_core #(
  parameter int unsigned STORE_SLOTS = cfla_pkg::StoreSlotsDef,
  parameter int unsigned MAX_CHUNKS  = cfla_pkg::MaxChunksDef,
  parameter int unsigned CHUNK_CAP   = cfla_pkg::ChunkCapDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cfla_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      start,
  input  cfla_pkg::req_t            req_i,
  output logic                      busy,
  output logic                      done_o,
  output cfla_pkg::rsp_t            rsp_o
);
  import cfla_pkg::*;

  localparam int unsigned AW  = $clog2(STORE_SLOTS);
  localparam int unsigned LW  = AW + 1;               // link incl. nil flag
  localparam int unsigned CW  = $clog2(MAX_CHUNKS);
  localparam int unsigned SW  = $clog2(CHUNK_CAP + 1); // chunk size width
  localparam int unsigned EW  = AW + 2;               // wide address math
  localparam logic [LW-1:0] NIL = LW'(STORE_SLOTS);

  typedef enum logic [17:0] {
    S_CLEAR  = 18'h00001,
    S_IDLE   = 18'h00002,
    S_DEC    = 18'h00004,
    S_LINK   = 18'h00008,
    S_ARD    = 18'h00010,
    S_AWR    = 18'h00020,
    S_FRD    = 18'h00040,
    S_FWR    = 18'h00080,
    S_GSCAN  = 18'h00100,
    S_GSWAIT = 18'h00200,
    S_GRD    = 18'h00400,
    S_GWAIT  = 18'h00800,
    S_GWR    = 18'h01000,
    S_RESP   = 18'h02000,
    S_LNKEND = 18'h04000,
    S_FCHK   = 18'h08000,
    S_GDONE  = 18'h10000,
    S_AHEAD  = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic             busy_mem [STORE_SLOTS];
  logic [CW-1:0]    own_mem  [STORE_SLOTS];
  logic [LW-1:0]    prev_mem [STORE_SLOTS];
  logic [LW-1:0]    next_mem [STORE_SLOTS];

  logic             bm_we, bm_wd;
  logic [AW-1:0]    bm_wa, bm_ra;
  logic             bm_rd;
  logic             om_we;
  logic [AW-1:0]    om_a;
  logic [CW-1:0]    om_wd, om_rd;
  logic             pm_we;
  logic [AW-1:0]    pm_wa, pm_ra;
  logic [LW-1:0]    pm_wd, pm_rd;
  logic             nm_we;
  logic [AW-1:0]    nm_wa, nm_ra;
  logic [LW-1:0]    nm_wd, nm_rd;

  always_ff @(posedge clk_i) begin
    if (bm_we) busy_mem[bm_wa] <= bm_wd;
    bm_rd <= busy_mem[bm_ra];
    if (om_we) own_mem[om_a] <= om_wd;
    om_rd <= own_mem[om_a];
    if (pm_we) prev_mem[pm_wa] <= pm_wd;
    pm_rd <= prev_mem[pm_ra];
    if (nm_we) next_mem[nm_wa] <= nm_wd;
    nm_rd <= next_mem[nm_ra];
  end

  // chunk table in flops (small)
  logic [AW-1:0]   cbase_q [MAX_CHUNKS];
  logic [SW-1:0]   csize_q [MAX_CHUNKS];
  logic [CfgW-1:0] cfg_q;
  logic [CW-1:0]   newest_q;
  logic [LW-1:0]   head_q, tail_q;
  logic [LW-1:0]   prevl_q;           // running prev while linking
  logic [EW-1:0]   ptr_q;             // walk pointer
  logic [EW-1:0]   end_q;             // walk end (exclusive)
  logic [EW-1:0]   clr_q;             // clear sweep pointer
  logic            link_done_q;
  logic [AW-1:0]   slot_q;            // operand slot
  logic [LW-1:0]   p_q, q_q;          // gc neighbor links
  rsp_t            rsp_q;
  logic            done_q;
  logic            scan_hit_q;
  logic            cfg_pend_q;

  // first chunk size, saturated
  logic [SW-1:0] first_n;
  always_comb begin
    logic [CfgW:0] n;
    n = {1'b0, cfg_q};
    if (n == '0) n = (CfgW+1)'(1);
    if (32'(n) > CHUNK_CAP) n = (CfgW+1)'(CHUNK_CAP);
    if (32'(n) > STORE_SLOTS) n = (CfgW+1)'(STORE_SLOTS);
    first_n = SW'(n);
  end

  // growth geometry
  logic [EW-1:0] grow_n, grow_base;
  logic          grow_ok;
  always_comb begin
    logic [EW:0] n2;
    n2 = (EW+1)'(csize_q[newest_q]) << 1;
    if (n2 > (EW+1)'(CHUNK_CAP)) n2 = (EW+1)'(CHUNK_CAP);
    grow_n    = EW'(n2);
    grow_base = EW'(cbase_q[newest_q]) + EW'(csize_q[newest_q]);
    grow_ok   = (32'(newest_q) + 1 < MAX_CHUNKS) &&
                ({1'b0, grow_base} + {1'b0, grow_n} <= (EW+1)'(STORE_SLOTS));
  end

  logic [AW-1:0] ptr_a;
  assign ptr_a = ptr_q[AW-1:0];
  logic          slot_ok;
  assign slot_ok = (32'(req_i.slot_in) < STORE_SLOTS);

  logic [LW-1:0]   head_d, tail_d, prevl_d, p_d, q_d;
  logic [EW-1:0]   ptr_d, end_d, clr_d;
  logic [CW-1:0]   newest_d;
  logic [AW-1:0]   slot_d;
  rsp_t            rsp_d;
  logic            done_d, link_done_d, scan_hit_d, cfg_pend_d;
  logic            tbl_we, tbl_clr;
  logic [CW-1:0]   tbl_idx;
  logic [AW-1:0]   tbl_base;
  logic [SW-1:0]   tbl_size;

  always_comb begin
    state_d = state_q;
    head_d = head_q; tail_d = tail_q; prevl_d = prevl_q;
    ptr_d = ptr_q; end_d = end_q; clr_d = clr_q;
    newest_d = newest_q; slot_d = slot_q; p_d = p_q; q_d = q_q;
    rsp_d = rsp_q; done_d = 1'b0; link_done_d = link_done_q;
    scan_hit_d = scan_hit_q; cfg_pend_d = cfg_pend_q;
    tbl_we = 1'b0; tbl_clr = 1'b0; tbl_idx = newest_q;
    tbl_base = '0; tbl_size = '0;
    bm_we = 1'b0; bm_wd = 1'b0; bm_wa = '0; bm_ra = ptr_a;
    om_we = 1'b0; om_a = ptr_a; om_wd = newest_q;
    pm_we = 1'b0; pm_wa = ptr_a; pm_ra = ptr_a; pm_wd = '0;
    nm_we = 1'b0; nm_wa = ptr_a; nm_ra = ptr_a; nm_wd = '0;

    case (state_q)
      S_CLEAR: begin
        // sweep busy flags; link chunk 0 in parallel
        if (32'(clr_q) < STORE_SLOTS) begin
          bm_we = 1'b1; bm_wa = clr_q[AW-1:0]; bm_wd = 1'b0;
          clr_d = clr_q + EW'(1);
        end
        if (!link_done_q) begin
          if (ptr_q < end_q) begin
            om_we = 1'b1; om_a = ptr_a;
            pm_we = 1'b1; pm_wd = prevl_q;
            if (prevl_q != NIL) begin
              nm_we = 1'b1; nm_wa = prevl_q[AW-1:0]; nm_wd = {1'b0, ptr_a};
            end
            prevl_d = {1'b0, ptr_a};
            ptr_d = ptr_q + EW'(1);
          end else begin
            nm_we = 1'b1; nm_wa = prevl_q[AW-1:0]; nm_wd = NIL;
            tail_d = prevl_q;
            link_done_d = 1'b1;
          end
        end
        if (link_done_q && 32'(clr_q) >= STORE_SLOTS) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          slot_d = req_i.slot_in[AW-1:0];
          rsp_d = '0;
          case (cmd_e'(req_i.cmd))
            CMD_ALLOC: begin
              if (head_q == NIL) begin
                if (grow_ok) begin
                  newest_d = newest_q + CW'(1);
                  tbl_we = 1'b1; tbl_idx = newest_q + CW'(1);
                  tbl_base = grow_base[AW-1:0]; tbl_size = SW'(grow_n);
                  ptr_d = grow_base; end_d = grow_base + grow_n;
                  prevl_d = tail_q;
                  state_d = S_LINK;
                end else begin
                  rsp_d.status = ST_NO_SPACE;
                  state_d = S_RESP;
                end
              end else state_d = S_AHEAD;
            end
            CMD_FREE: begin
              if (!slot_ok) begin
                rsp_d.status = ST_BAD_FREE;
                state_d = S_RESP;
              end else begin
                bm_ra = req_i.slot_in[AW-1:0];
                om_a  = req_i.slot_in[AW-1:0];
                state_d = S_FCHK;
              end
            end
            CMD_GC: begin
              if (newest_q == '0) begin
                rsp_d.status = ST_GC_KEPT;
                state_d = S_RESP;
              end else begin
                ptr_d = EW'(cbase_q[newest_q]);
                end_d = EW'(cbase_q[newest_q]) + EW'(csize_q[newest_q]);
                scan_hit_d = 1'b0;
                state_d = S_GSCAN;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_LINK: begin
        if (ptr_q < end_q) begin
          bm_we = 1'b1; bm_wa = ptr_a; bm_wd = 1'b0;
          om_we = 1'b1; om_a = ptr_a;
          pm_we = 1'b1; pm_wd = prevl_q;
          if (prevl_q != NIL) begin
            nm_we = 1'b1; nm_wa = prevl_q[AW-1:0]; nm_wd = {1'b0, ptr_a};
          end
          prevl_d = {1'b0, ptr_a};
          ptr_d = ptr_q + EW'(1);
        end else begin
          nm_we = 1'b1; nm_wa = prevl_q[AW-1:0]; nm_wd = NIL;
          tail_d = prevl_q;
          if (head_q == NIL) head_d = {1'b0, cbase_q[newest_q]};
          state_d = S_LNKEND;
        end
      end

      S_LNKEND: state_d = S_AHEAD;

      S_AHEAD: begin
        nm_ra = head_q[AW-1:0];
        state_d = S_ARD;
      end

      S_ARD: begin
        // nm_rd = next of head
        slot_d = head_q[AW-1:0];
        if (nm_rd != NIL) begin
          pm_we = 1'b1; pm_wa = nm_rd[AW-1:0]; pm_wd = NIL;
          head_d = nm_rd;
        end else begin
          head_d = NIL; tail_d = NIL;
        end
        state_d = S_AWR;
      end

      S_AWR: begin
        bm_we = 1'b1; bm_wa = slot_q; bm_wd = 1'b1;
        pm_we = 1'b1; pm_wa = slot_q; pm_wd = NIL;
        nm_we = 1'b1; nm_wa = slot_q; nm_wd = NIL;
        rsp_d.status = ST_DONE;
        rsp_d.slot_out = SlotW'(slot_q);
        state_d = S_RESP;
      end

      S_FCHK: begin
        // reissue both reads so they line up with S_FRD
        bm_ra = slot_q;
        om_a = slot_q;
        state_d = S_FRD;
      end

      S_FRD: begin
        if (!bm_rd) begin
          rsp_d.status = ST_BAD_FREE;
          state_d = S_RESP;
        end else begin
          bm_we = 1'b1; bm_wa = slot_q; bm_wd = 1'b0;
          if (head_q == NIL) begin
            head_d = {1'b0, slot_q}; tail_d = {1'b0, slot_q};
            pm_we = 1'b1; pm_wa = slot_q; pm_wd = NIL;
            nm_we = 1'b1; nm_wa = slot_q; nm_wd = NIL;
          end else if (om_rd == newest_q) begin
            nm_we = 1'b1; nm_wa = tail_q[AW-1:0]; nm_wd = {1'b0, slot_q};
            pm_we = 1'b1; pm_wa = slot_q; pm_wd = tail_q;
            tail_d = {1'b0, slot_q};
          end else begin
            pm_we = 1'b1; pm_wa = head_q[AW-1:0]; pm_wd = {1'b0, slot_q};
            nm_we = 1'b1; nm_wa = slot_q; nm_wd = head_q;
            head_d = {1'b0, slot_q};
          end
          state_d = S_FWR;
        end
      end

      S_FWR: begin
        // second half: remaining link of the freed slot
        if (head_q != NIL && tail_q == {1'b0, slot_q} && head_q != tail_q) begin
          nm_we = 1'b1; nm_wa = slot_q; nm_wd = NIL;
        end else if (head_q == {1'b0, slot_q} && tail_q != head_q) begin
          pm_we = 1'b1; pm_wa = slot_q; pm_wd = NIL;
        end
        rsp_d.status = ST_DONE;
        state_d = S_RESP;
      end

      S_GSCAN: begin
        // issue busy reads, check each result in the next cycle
        if (ptr_q < end_q) begin
          bm_ra = ptr_a;
          ptr_d = ptr_q + EW'(1);
        end
        if (ptr_q != EW'(cbase_q[newest_q]) && bm_rd) scan_hit_d = 1'b1;
        if (ptr_q >= end_q) state_d = S_GSWAIT;
      end

      S_GSWAIT: begin
        if (scan_hit_q) begin
          rsp_d.status = ST_GC_KEPT;
          state_d = S_RESP;
        end else begin
          ptr_d = EW'(cbase_q[newest_q]);
          state_d = S_GRD;
        end
      end

      S_GRD: begin
        if (ptr_q < end_q) begin
          pm_ra = ptr_a; nm_ra = ptr_a;
          state_d = S_GWAIT;
        end else begin
          tbl_clr = 1'b1;
          newest_d = newest_q - CW'(1);
          rsp_d.status = ST_DONE;
          state_d = S_GDONE;
        end
      end

      S_GWAIT: begin
        p_d = pm_rd; q_d = nm_rd;
        state_d = S_GWR;
      end

      S_GWR: begin
        if (p_q != NIL) begin
          nm_we = 1'b1; nm_wa = p_q[AW-1:0]; nm_wd = q_q;
        end else head_d = q_q;
        if (q_q != NIL) begin
          pm_we = 1'b1; pm_wa = q_q[AW-1:0]; pm_wd = p_q;
        end else tail_d = p_q;
        ptr_d = ptr_q + EW'(1);
        state_d = S_GRD;
      end

      S_GDONE: state_d = S_RESP;

      S_RESP: begin
        rsp_d.chunks_open = OpenW'(newest_q) + OpenW'(1);
        done_d = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cfg_q <= CfgW'(FirstSlotsRst);
      newest_q <= '0;
      head_q <= '0;
      tail_q <= NIL;
      prevl_q <= NIL;
      ptr_q <= '0;
      end_q <= EW'(FirstSlotsRst);
      clr_q <= '0;
      link_done_q <= 1'b0;
      done_q <= 1'b0;
      scan_hit_q <= 1'b0;
      cfg_pend_q <= 1'b0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        cbase_q[i] <= '0;
        csize_q[i] <= '0;
      end
      csize_q[0] <= SW'(FirstSlotsRst);
    end else if (cfg_we_i || cfg_pend_q) begin
      // rebuild: latch the size first, then reset the table and start the clearing pass
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
        cfg_pend_q <= 1'b1;
        state_q <= S_CLEAR;
      end else begin
        cfg_pend_q <= 1'b0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
          cbase_q[i] <= '0;
          csize_q[i] <= '0;
        end
        csize_q[0] <= first_n;
        newest_q <= '0;
        head_q <= '0;
        tail_q <= NIL;
        prevl_q <= NIL;
        ptr_q <= '0;
        end_q <= EW'(first_n);
        clr_q <= '0;
        link_done_q <= 1'b0;
        state_q <= S_CLEAR;
      end
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      newest_q <= newest_d;
      head_q <= head_d;
      tail_q <= tail_d;
      prevl_q <= prevl_d;
      ptr_q <= ptr_d;
      end_q <= end_d;
      clr_q <= clr_d;
      link_done_q <= link_done_d;
      done_q <= done_d;
      scan_hit_q <= scan_hit_d;
      if (tbl_we) begin
        cbase_q[tbl_idx] <= tbl_base;
        csize_q[tbl_idx] <= tbl_size;
      end
      if (tbl_clr) begin
        cbase_q[newest_q] <= '0;
        csize_q[newest_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    p_q <= p_d;
    q_q <= q_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE) || cfg_pend_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== hdl/cfla_checker.sv =====
module cfla_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cfg_we_i,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input cfla_pkg::rsp_t rsp_o
);
  import cfla_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i) |=> busy)
    else $error("busy not raised after accept");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a pending item");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results back to back");

  a_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.chunks_open != '0)
    else $error("chunk count zero");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_DONE) |-> rsp_o.slot_out == '0)
    else $error("slot reported on failure");

endmodule

bind chunked_free_list_allocator_core cfla_checker u_cfla_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .cfg_we_i(cfg_we_i),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
